[src/gapr_pkg.sv]
// Shared types and constants for the int8 global average pool with requantization.
package gapr_pkg;

	// Field widths.
	localparam int unsigned SUM_W   = 25;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned INDEX_W = 3;

	typedef logic signed [7:0]       int8_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_IN_OFFSET  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_MULT       = 3'd1;
	localparam logic [INDEX_W-1:0] REG_SHIFT      = 3'd2;
	localparam logic [INDEX_W-1:0] REG_OUT_OFFSET = 3'd3;
	localparam logic [INDEX_W-1:0] REG_ACT_MIN    = 3'd4;
	localparam logic [INDEX_W-1:0] REG_ACT_MAX    = 3'd5;

	// Register reset values.
	localparam int8_t              RST_IN_OFFSET  = 8'sd0;
	localparam logic signed [31:0] RST_MULT       = 32'sd1073741824;
	localparam logic signed [5:0]  RST_SHIFT      = 6'sd1;
	localparam int8_t              RST_OUT_OFFSET = 8'sd0;
	localparam int8_t              RST_ACT_MIN    = -8'sd128;
	localparam int8_t              RST_ACT_MAX    = 8'sd127;

	// Accumulator saturation limits.
	localparam logic signed [SUM_W:0] SUM_MAX = 26'sd16777215;
	localparam logic signed [SUM_W:0] SUM_MIN = -26'sd16777216;

	// Requantization constants.
	localparam logic signed [31:0] WORD_MAX    = 32'sh7fffffff;
	localparam logic signed [31:0] WORD_MIN    = 32'sh80000000;
	localparam logic signed [63:0] NUDGE_POS   = 64'sd1073741824;
	localparam logic signed [63:0] NUDGE_NEG   = -64'sd1073741823;
	localparam logic [5:0]         RSHIFT_FULL = 6'd32;

	// Configuration as seen by the datapath.
	typedef struct packed {
		int8_t              in_offset;
		logic signed [31:0] mult;
		logic signed [5:0]  shift;
		int8_t              out_offset;
		int8_t              act_min;
		int8_t              act_max;
	} cfg_t;

	// Front to queue: a finished plane sum.
	typedef struct packed {
		logic valid;
		sum_t sum;
	} push_t;

	// Queue to back: head entry.
	typedef struct packed {
		logic valid;
		sum_t sum;
	} head_t;

endpackage

[src/gapr_if.sv]
// Valid/ready channel interfaces for sample words and result words.
interface gapr_in_if import gapr_pkg::*; ();
	logic  valid;
	logic  ready;
	int8_t sample;
	logic  last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface gapr_out_if import gapr_pkg::*; ();
	logic  valid;
	logic  ready;
	int8_t pooled_value;

	modport source (output valid, output pooled_value, input ready);
	modport sink (input valid, input pooled_value, output ready);
endinterface

[src/gapr_front.sv]
// Front end: accepts sample words and accumulates each channel plane.
module gapr_front import gapr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  int8_t sample,
	input  logic  last,
	input  logic  queue_full,
	output push_t push
);

	sum_t                  sum_q;
	logic                  accept;
	logic signed [SUM_W:0] sum_wide;
	sum_t                  sum_sat;

	// A word is taken whenever the queue can hold a finished sum.
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Add the sample less the zero point and saturate to the accumulator range.
	always_comb begin
		sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(sample) - (SUM_W+1)'(cfg.in_offset);
		if (sum_wide > SUM_MAX) begin
			sum_sat = SUM_MAX[SUM_W-1:0];
		end else if (sum_wide < SUM_MIN) begin
			sum_sat = SUM_MIN[SUM_W-1:0];
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	// The last word of a plane hands its sum to the queue.
	assign push.valid = accept && last;
	assign push.sum   = sum_sat;

	// Accumulator, cleared after each plane.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			sum_q <= last ? '0 : sum_sat;
		end
	end

`ifndef SYNTH
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> sum_q == '0)
		else $error("Accumulator not cleared after the last word of a plane.");
`endif

endmodule

[src/gapr_fifo.sv]
// Short queue of finished plane sums between the front and back ends.
module gapr_fifo import gapr_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  full,
	output head_t head,
	input  logic  pop
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	sum_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head.valid = count_q != '0;
	assign head.sum   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	// Storage; entries carry no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.sum;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Queue fill count beyond its depth.");
	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("Sum pushed into a full queue.");
`endif

endmodule

[src/gapr_back.sv]
// Back end: requantization pipeline with a registered result word.
module gapr_back import gapr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  head_t head,
	output logic  pop,
	output logic  out_valid,
	input  logic  out_ready,
	output int8_t pooled_value
);

	logic                  advance;
	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_q;
	logic signed [31:0]    lsh_s1;
	logic signed [63:0]    prod_s2;
	logic                  both_min_s2, both_min_s3;
	logic signed [63:0]    nudged_s3;
	logic signed [31:0]    high_s4;
	logic signed [31:0]    round_s5;
	int8_t                 result_q;

	logic [4:0]            lshift;
	logic [5:0]            rshift;
	logic signed [56:0]    lsh_wide;
	logic                  lsh_ovf;
	logic signed [31:0]    lsh_sat;
	logic                  high_corr;
	logic [31:0]           rmask;
	logic [31:0]           rrem;
	logic [31:0]           rthr;
	logic signed [31:0]    rshifted;
	logic signed [31:0]    rounded;
	logic signed [33:0]    offset;
	logic signed [33:0]    clamped;

	// The whole pipeline moves unless the result word is stalled.
	assign advance   = !(vld_q && !out_ready);
	assign pop       = advance && head.valid;
	assign out_valid = vld_q;
	assign pooled_value = result_q;

	// Split the signed shift into a left and a right amount.
	assign lshift = (cfg.shift > 6'sd0) ? cfg.shift[4:0] : 5'd0;
	assign rshift = (cfg.shift > 6'sd0) ? 6'd0 : 6'(-cfg.shift);

	// Stage 1: saturating left shift to 32 bits.
	always_comb begin
		lsh_wide = 57'(head.sum) <<< lshift;
		lsh_ovf  = lsh_wide[56:31] != {26{lsh_wide[31]}};
		if (lsh_ovf) begin
			lsh_sat = lsh_wide[56] ? WORD_MIN : WORD_MAX;
		end else begin
			lsh_sat = lsh_wide[31:0];
		end
	end

	// Stage 4: truncate toward zero after the nudge.
	assign high_corr = nudged_s3[63] && (nudged_s3[30:0] != '0);

	// Stage 5: rounding right shift.
	always_comb begin
		rmask    = (32'd1 << rshift[4:0]) - 32'd1;
		rrem     = high_s4 & rmask;
		rthr     = (rmask >> 1) + {31'd0, high_s4[31]};
		rshifted = high_s4 >>> rshift[4:0];
		if (rshift == RSHIFT_FULL) begin
			rounded = high_s4[31] ? -32'sd1 : 32'sd0;
		end else begin
			rounded = rshifted + ((rrem > rthr) ? 32'sd1 : 32'sd0);
		end
	end

	// Output stage: add the zero point and clamp; max bound applies last.
	always_comb begin
		offset = 34'(round_s5) + 34'(cfg.out_offset);
		clamped = offset;
		if (clamped < 34'(cfg.act_min)) begin
			clamped = 34'(cfg.act_min);
		end
		if (clamped > 34'(cfg.act_max)) begin
			clamped = 34'(cfg.act_max);
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (advance) begin
			vld_s1 <= head.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_q  <= vld_s5;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (advance) begin
			lsh_s1      <= lsh_sat;
			prod_s2     <= 64'(lsh_s1) * 64'(cfg.mult);
			both_min_s2 <= (lsh_s1 == WORD_MIN) && (cfg.mult == WORD_MIN);
			nudged_s3   <= prod_s2 + (prod_s2[63] ? NUDGE_NEG : NUDGE_POS);
			both_min_s3 <= both_min_s2;
			high_s4     <= both_min_s3 ? WORD_MAX : nudged_s3[62:31] + {31'd0, high_corr};
			round_s5    <= rounded;
			result_q    <= clamped[7:0];
		end
	end

`ifndef SYNTH
	a_result_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_q) |-> $past(vld_s5))
		else $error("Result word appeared without a value in the last stage.");
`endif

endmodule

[src/int8_global_average_pool_requant.sv]
// Top level: int8 global average pooling with fixed-point requantization.
// Throughput: one sample word per cycle; a plane's result is one word per last sample.
// The result of a last sample passes through the sum queue, the five requantization
// stages and the registered result word.
// Input stalls only when the sum queue of QUEUE_DEPTH entries is full.
// Reset clears the accumulator, queue and pipeline and loads register defaults; no sweep.
module int8_global_average_pool_requant import gapr_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	gapr_in_if.sink            in_ch,
	gapr_out_if.source         out_ch
);

	cfg_t  cfg_q;
	push_t push;
	head_t head;
	logic  queue_full;
	logic  pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_offset  <= RST_IN_OFFSET;
			cfg_q.mult       <= RST_MULT;
			cfg_q.shift      <= RST_SHIFT;
			cfg_q.out_offset <= RST_OUT_OFFSET;
			cfg_q.act_min    <= RST_ACT_MIN;
			cfg_q.act_max    <= RST_ACT_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IN_OFFSET:  cfg_q.in_offset  <= cfg_wdata[7:0];
				REG_MULT:       cfg_q.mult       <= cfg_wdata;
				REG_SHIFT:      cfg_q.shift      <= cfg_wdata[5:0];
				REG_OUT_OFFSET: cfg_q.out_offset <= cfg_wdata[7:0];
				REG_ACT_MIN:    cfg_q.act_min    <= cfg_wdata[7:0];
				REG_ACT_MAX:    cfg_q.act_max    <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Accumulating front end.
	gapr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.sample     (in_ch.sample),
		.last       (in_ch.last),
		.queue_full (queue_full),
		.push       (push)
	);

	// Queue of finished sums.
	gapr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.head   (head),
		.pop    (pop)
	);

	// Requantizing back end.
	gapr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.pooled_value (out_ch.pooled_value)
	);

endmodule
